[design/lcd_pkg.sv]
// ----------------------------------------------------------------------------
// lcd_pkg: shared types, codes and helpers for the lattice cell distance core
// Register codes, shape codes, pipeline structs and per-step arithmetic.
// ----------------------------------------------------------------------------
package lcd_pkg;

	localparam int COORD_W  = 8;
	localparam int SIDE_W   = 9;
	localparam int DIST_W   = 10;
	localparam int SQ_W     = 17;
	localparam int RAD_W    = 18;
	localparam int ROOT_W   = 9;
	localparam int REM_W    = 11;
	localparam int HEX_W    = 12;
	localparam int HMAG_W   = 11;
	localparam int HEX_CANDS = 7;
	localparam int ROOT_STEPS = 3;

	localparam logic [SIDE_W-1:0] MAX_SIDE = 9'd256;

	typedef enum logic [1:0] {
		CFG_WRAP,
		CFG_SHAPE,
		CFG_HEIGHT,
		CFG_WIDTH
	} cfg_idx_t;

	typedef enum logic [1:0] {
		SHAPE_CIRCLE,
		SHAPE_HEX,
		SHAPE_SQUARE
	} shape_t;

	// shift bits per candidate: {first row +h, first col +w, second row +h, second col +w}
	localparam logic [3:0] HEX_SHIFT [HEX_CANDS] = '{
		4'b0000, 4'b0010, 4'b0001, 4'b0011, 4'b1000, 4'b0100, 4'b1100
	};

	typedef struct packed {
		logic signed [HEX_W-1:0] a;
		logic signed [HEX_W-1:0] b;
		logic signed [HEX_W-1:0] c;
	} hex_parts_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} root_t;

	function automatic logic [COORD_W-1:0] axis_wrap(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b, input logic [SIDE_W-1:0] size);
		logic [COORD_W-1:0] d;
		logic signed [SIDE_W:0] e;
		logic signed [SIDE_W:0] ne;
		logic [COORD_W-1:0] r;
		d  = (a > b) ? a - b : b - a;
		e  = $signed({1'b0, size}) - $signed({2'b00, d});
		ne = -e;
		if ($signed({2'b00, d}) < e) begin
			r = d;
		end else if (e < 0) begin
			r = ne[COORD_W-1:0];
		end else begin
			r = e[COORD_W-1:0];
		end
		return r;
	endfunction

	function automatic hex_parts_t hex_parts(input logic [COORD_W-1:0] r1,
			input logic [COORD_W-1:0] c1, input logic [COORD_W-1:0] r2,
			input logic [COORD_W-1:0] c2, input logic [SIDE_W-1:0] gh,
			input logic [SIDE_W-1:0] gw, input logic [3:0] sh);
		logic [SIDE_W:0] r1x, c1x, r2x, c2x;
		logic signed [HEX_W-1:0] dr, dc, hh;
		hex_parts_t p;
		r1x = {2'b00, r1} + (sh[3] ? {1'b0, gh} : '0);
		c1x = {2'b00, c1} + (sh[2] ? {1'b0, gw} : '0);
		r2x = {2'b00, r2} + (sh[1] ? {1'b0, gh} : '0);
		c2x = {2'b00, c2} + (sh[0] ? {1'b0, gw} : '0);
		dr  = $signed({2'b00, r1x}) - $signed({2'b00, r2x});
		dc  = $signed({2'b00, c1x}) - $signed({2'b00, c2x});
		hh  = $signed({3'b000, r1x[SIDE_W:1]}) - $signed({3'b000, r2x[SIDE_W:1]});
		p.a = dr;
		p.b = dc - hh;
		p.c = dc + dr - hh;
		return p;
	endfunction

	function automatic logic [HMAG_W-1:0] hex_mag(input logic signed [HEX_W-1:0] v);
		logic signed [HEX_W-1:0] n;
		n = -v;
		return (v < 0) ? n[HMAG_W-1:0] : v[HMAG_W-1:0];
	endfunction

	// one digit of the restoring square root
	function automatic root_t root_step(input root_t x);
		logic [REM_W+1:0] rem2;
		logic [REM_W+1:0] trial;
		logic [REM_W+1:0] diff;
		root_t y;
		rem2  = {x.rem, x.rad[RAD_W-1 -: 2]};
		trial = {{(REM_W-ROOT_W){1'b0}}, x.root, 2'b01};
		diff  = rem2 - trial;
		y.rad = {x.rad[RAD_W-3:0], 2'b00};
		if (rem2 >= trial) begin
			y.rem  = diff[REM_W-1:0];
			y.root = {x.root[ROOT_W-2:0], 1'b1};
		end else begin
			y.rem  = rem2[REM_W-1:0];
			y.root = {x.root[ROOT_W-2:0], 1'b0};
		end
		return y;
	endfunction

endpackage

[design/lcd_pair_if.sv]
// ----------------------------------------------------------------------------
// lcd_pair_if: cell pair request channel
// Valid/ready handshake carrying the two cell coordinates.
// ----------------------------------------------------------------------------
interface lcd_pair_if;
	logic       valid;
	logic       ready;
	logic [7:0] first_row;
	logic [7:0] first_col;
	logic [7:0] second_row;
	logic [7:0] second_col;

	modport source (output valid, output first_row, output first_col,
		output second_row, output second_col, input ready);
	modport sink (input valid, input first_row, input first_col,
		input second_row, input second_col, output ready);
endinterface

[design/lcd_dist_if.sv]
// ----------------------------------------------------------------------------
// lcd_dist_if: distance result channel
// Valid/ready handshake carrying one lattice distance.
// ----------------------------------------------------------------------------
interface lcd_dist_if;
	logic       valid;
	logic       ready;
	logic [9:0] cell_distance;

	modport source (output valid, output cell_distance, input ready);
	modport sink (input valid, input cell_distance, output ready);
endinterface

[design/lcd_root_stage.sv]
// ----------------------------------------------------------------------------
// lcd_root_stage: one registered slice of the square root pipeline
// Resolves three root digits per stage and holds them while stalled.
// ----------------------------------------------------------------------------
module lcd_root_stage (
	input  logic           clk,
	input  logic           en,
	input  lcd_pkg::root_t d,
	output lcd_pkg::root_t q
);

	lcd_pkg::root_t nxt;
	lcd_pkg::root_t q_q;

	always_comb begin
		nxt = d;
		for (int i = 0; i < lcd_pkg::ROOT_STEPS; i++) begin
			nxt = lcd_pkg::root_step(nxt);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_q <= nxt;
		end
	end

	assign q = q_q;

endmodule

[design/lattice_cell_distance_core.sv]
// ----------------------------------------------------------------------------
// lattice_cell_distance_core: distance between two cells of a map lattice
// Throughput: one request per cycle while the output is taken; the
// six-stage pipeline, with the nine-digit square root spread over three
// stages, sets that figure.
// Reset: clears all stage valids and loads plane, square, 256 x 256 settings.
// ----------------------------------------------------------------------------
module lattice_cell_distance_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [8:0]       cfg_data,
	lcd_pair_if.sink         pair_req,
	lcd_dist_if.source       dist_rsp
);

	logic                             wrap_q;
	logic [1:0]                       shape_q;
	logic [lcd_pkg::SIDE_W-1:0]       height_q;
	logic [lcd_pkg::SIDE_W-1:0]       width_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	logic [lcd_pkg::COORD_W-1:0]      dr_s1, dc_s1;
	lcd_pkg::hex_parts_t              hp_s1 [lcd_pkg::HEX_CANDS];

	logic [lcd_pkg::SQ_W-1:0]         sq_s2;
	logic [lcd_pkg::COORD_W-1:0]      cheb_s2;
	logic [lcd_pkg::HMAG_W-1:0]       hmax_s2 [lcd_pkg::HEX_CANDS];

	logic [lcd_pkg::COORD_W-1:0]      cheb_s3, cheb_s4, cheb_s5;
	logic [lcd_pkg::HMAG_W-1:0]       hex_s3, hex_s4, hex_s5;
	lcd_pkg::root_t                   root_in, root_s3, root_s4, root_s5;

	logic [lcd_pkg::DIST_W-1:0]       dist_s6;

	logic [lcd_pkg::COORD_W-1:0]      dr_d, dc_d;
	lcd_pkg::hex_parts_t              hp_d [lcd_pkg::HEX_CANDS];
	logic [lcd_pkg::HMAG_W-1:0]       hmax_d [lcd_pkg::HEX_CANDS];
	logic [lcd_pkg::HMAG_W-1:0]       hmin_d;
	logic [lcd_pkg::DIST_W-1:0]       circ_d;
	logic [lcd_pkg::DIST_W-1:0]       dist_d;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q   <= 1'b0;
			shape_q  <= lcd_pkg::SHAPE_SQUARE;
			height_q <= lcd_pkg::MAX_SIDE;
			width_q  <= lcd_pkg::MAX_SIDE;
		end else if (cfg_we) begin
			case (cfg_idx)
				lcd_pkg::CFG_WRAP:   wrap_q   <= cfg_data[0];
				lcd_pkg::CFG_SHAPE:  shape_q  <= cfg_data[1:0];
				lcd_pkg::CFG_HEIGHT: height_q <= cfg_data;
				lcd_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stall chain, bubbles collapse
	assign en6 = !v_s6 || dist_rsp.ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pair_req.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pair_req.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// stage 1: axis offsets and hex candidate terms
	always_comb begin
		if (wrap_q) begin
			dr_d = lcd_pkg::axis_wrap(pair_req.first_row, pair_req.second_row, height_q);
			dc_d = lcd_pkg::axis_wrap(pair_req.first_col, pair_req.second_col, width_q);
		end else begin
			dr_d = (pair_req.first_row > pair_req.second_row) ?
				pair_req.first_row - pair_req.second_row :
				pair_req.second_row - pair_req.first_row;
			dc_d = (pair_req.first_col > pair_req.second_col) ?
				pair_req.first_col - pair_req.second_col :
				pair_req.second_col - pair_req.first_col;
		end
		for (int k = 0; k < lcd_pkg::HEX_CANDS; k++) begin
			hp_d[k] = lcd_pkg::hex_parts(pair_req.first_row, pair_req.first_col,
				pair_req.second_row, pair_req.second_col, height_q, width_q,
				lcd_pkg::HEX_SHIFT[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			dr_s1 <= dr_d;
			dc_s1 <= dc_d;
			hp_s1 <= hp_d;
		end
	end

	// stage 2: squares, chebyshev, per-candidate hex max
	always_comb begin
		logic [lcd_pkg::HMAG_W-1:0] ma, mb, mc, m;
		for (int k = 0; k < lcd_pkg::HEX_CANDS; k++) begin
			ma = lcd_pkg::hex_mag(hp_s1[k].a);
			mb = lcd_pkg::hex_mag(hp_s1[k].b);
			mc = lcd_pkg::hex_mag(hp_s1[k].c);
			m  = (ma > mb) ? ma : mb;
			hmax_d[k] = (m > mc) ? m : mc;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			sq_s2   <= lcd_pkg::SQ_W'({9'd0, dr_s1} * {9'd0, dr_s1}) +
				lcd_pkg::SQ_W'({9'd0, dc_s1} * {9'd0, dc_s1});
			cheb_s2 <= (dr_s1 > dc_s1) ? dr_s1 : dc_s1;
			hmax_s2 <= hmax_d;
		end
	end

	// stage 3: hex torus minimum, first root digits
	always_comb begin
		hmin_d = hmax_s2[0];
		for (int k = 1; k < lcd_pkg::HEX_CANDS; k++) begin
			if (hmax_s2[k] < hmin_d) hmin_d = hmax_s2[k];
		end
	end

	assign root_in.rad  = {1'b0, sq_s2};
	assign root_in.rem  = '0;
	assign root_in.root = '0;

	lcd_root_stage u_root_a (.clk(clk), .en(en3), .d(root_in), .q(root_s3));
	lcd_root_stage u_root_b (.clk(clk), .en(en4), .d(root_s3), .q(root_s4));
	lcd_root_stage u_root_c (.clk(clk), .en(en5), .d(root_s4), .q(root_s5));

	always_ff @(posedge clk) begin
		if (en3) begin
			hex_s3  <= wrap_q ? hmin_d : hmax_s2[0];
			cheb_s3 <= cheb_s2;
		end
		if (en4) begin
			hex_s4  <= hex_s3;
			cheb_s4 <= cheb_s3;
		end
		if (en5) begin
			hex_s5  <= hex_s4;
			cheb_s5 <= cheb_s4;
		end
	end

	// stage 6: ceiling of root and shape select
	assign circ_d = {1'b0, root_s5.root} +
		{{(lcd_pkg::DIST_W-1){1'b0}}, (root_s5.rem != '0)};

	always_comb begin
		case (shape_q)
			lcd_pkg::SHAPE_CIRCLE: dist_d = circ_d;
			lcd_pkg::SHAPE_HEX:    dist_d = hex_s5[lcd_pkg::DIST_W-1:0];
			lcd_pkg::SHAPE_SQUARE: dist_d = {2'b00, cheb_s5};
			default:               dist_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			dist_s6 <= dist_d;
		end
	end

	assign dist_rsp.valid         = v_s6;
	assign dist_rsp.cell_distance = dist_s6;

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		pair_req.valid && pair_req.ready |=> v_s1)
		else $error("accepted request did not reach stage 1");

	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> pair_req.ready)
		else $error("request refused with empty first stage");

	a_stage5_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !en6 |=> v_s5 && $stable(root_s5) && $stable(hex_s5))
		else $error("stage 5 changed under stall");

	a_root_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> {1'b0, root_s5.rem} <= {root_s5.root, 1'b0} + {2'b00, root_s5.root})
		else $error("square root remainder out of range");

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for lattice_cell_distance_core
// Drives cell pair requests under every wrap mode, cell shape and a range of
// grid sizes. A scoreboard predicts each distance and checks every result in
// order. Both handshakes idle in random bursts.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [1:0] SHAPE_UNUSED = 2'd3;
	localparam int PHASES       = 18;
	localparam int PHASE_ITEMS  = 50;
	localparam int TAIL_ITEMS   = 60;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [7:0] first_row;
		logic [7:0] first_col;
		logic [7:0] second_row;
		logic [7:0] second_col;
	} cell_pair_t;

	class dist_scoreboard;
		bit         torus;
		logic [1:0] shape;
		int         height;
		int         width;
		logic [9:0] expected_dist [$];
		int         mismatches;

		function new();
			torus      = 1'b0;
			shape      = lcd_pkg::SHAPE_SQUARE;
			height     = lcd_pkg::MAX_SIDE;
			width      = lcd_pkg::MAX_SIDE;
			mismatches = 0;
		endfunction

		function void set_reg(lcd_pkg::cfg_idx_t idx, logic [8:0] val);
			case (idx)
				lcd_pkg::CFG_WRAP:   torus  = val[0];
				lcd_pkg::CFG_SHAPE:  shape  = val[1:0];
				lcd_pkg::CFG_HEIGHT: height = val;
				lcd_pkg::CFG_WIDTH:  width  = val;
				default: ;
			endcase
		endfunction

		function int magnitude(int v);
			return (v < 0) ? -v : v;
		endfunction

		function int wrap_offset(int a, int b, int size);
			int d;
			int e;
			d = magnitude(a - b);
			e = size - d;
			return magnitude((d < e) ? d : e);
		endfunction

		function int ceil_sqrt(int s);
			int n;
			n = 0;
			while (n * n < s) n++;
			return n;
		endfunction

		function int hex_flat(int r1, int c1, int r2, int c2);
			int a;
			int b;
			int c;
			int m;
			a = magnitude(r1 - r2);
			b = magnitude(c1 - c2 - r1 / 2 + r2 / 2);
			c = magnitude(c1 - c2 + r1 - r2 - r1 / 2 + r2 / 2);
			m = (a > b) ? a : b;
			return (m > c) ? m : c;
		endfunction

		function int hex_wrapped(int r1, int c1, int r2, int c2);
			int cand [7];
			int best;
			cand[0] = hex_flat(r1, c1, r2, c2);
			cand[1] = hex_flat(r1, c1, r2 + height, c2);
			cand[2] = hex_flat(r1, c1, r2, c2 + width);
			cand[3] = hex_flat(r1, c1, r2 + height, c2 + width);
			cand[4] = hex_flat(r1 + height, c1, r2, c2);
			cand[5] = hex_flat(r1, c1 + width, r2, c2);
			cand[6] = hex_flat(r1 + height, c1 + width, r2, c2);
			best = cand[0];
			for (int k = 1; k < 7; k++) begin
				if (cand[k] < best) best = cand[k];
			end
			return best;
		endfunction

		function logic [9:0] predict_distance(cell_pair_t p);
			int r1;
			int c1;
			int r2;
			int c2;
			int dr;
			int dc;
			int span;
			r1 = p.first_row;
			c1 = p.first_col;
			r2 = p.second_row;
			c2 = p.second_col;
			if (torus) begin
				dr = wrap_offset(r1, r2, height);
				dc = wrap_offset(c1, c2, width);
			end else begin
				dr = magnitude(r1 - r2);
				dc = magnitude(c1 - c2);
			end
			case (shape)
				lcd_pkg::SHAPE_CIRCLE: span = ceil_sqrt(dr * dr + dc * dc);
				lcd_pkg::SHAPE_HEX:    span = torus ? hex_wrapped(r1, c1, r2, c2) :
					hex_flat(r1, c1, r2, c2);
				lcd_pkg::SHAPE_SQUARE: span = (dr > dc) ? dr : dc;
				default:               span = 0;
			endcase
			return span[9:0];
		endfunction

		function void note_pair(cell_pair_t p);
			expected_dist.push_back(predict_distance(p));
		endfunction

		function void check_dist(logic [9:0] actual);
			logic [9:0] want;
			if (expected_dist.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected distance %0d with no request pending", actual);
				return;
			end
			want = expected_dist.pop_front();
			if (actual !== want) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("cell_distance mismatch: expected %0d, got %0d", want, actual);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_idx;
	logic [8:0] cfg_data;
	bit         idle_on = 1'b1;

	lcd_pair_if pair_ch ();
	lcd_dist_if dist_ch ();

	dist_scoreboard board = new();

	lattice_cell_distance_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.pair_req (pair_ch),
		.dist_rsp (dist_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result sink with random stalls
	initial begin
		forever begin
			if (idle_on && $urandom_range(0, 5) == 0) begin
				dist_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			dist_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && dist_ch.valid && dist_ch.ready)
			board.check_dist(dist_ch.cell_distance);
	end

	task automatic send_pair(cell_pair_t p);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			pair_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		pair_ch.valid      <= 1'b1;
		pair_ch.first_row  <= p.first_row;
		pair_ch.first_col  <= p.first_col;
		pair_ch.second_row <= p.second_row;
		pair_ch.second_col <= p.second_col;
		@(posedge clk);
		while (!pair_ch.ready) @(posedge clk);
		board.note_pair(p);
	endtask

	task automatic send_cells(int r1, int c1, int r2, int c2);
		cell_pair_t p;
		p.first_row  = 8'(r1);
		p.first_col  = 8'(c1);
		p.second_row = 8'(r2);
		p.second_col = 8'(c2);
		send_pair(p);
	endtask

	// hold requests off until every pending distance has come back
	task automatic settle();
		pair_ch.valid <= 1'b0;
		while (board.expected_dist.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(lcd_pkg::cfg_idx_t idx, logic [8:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		board.set_reg(idx, val);
	endtask

	task automatic apply_config(bit wrap, logic [1:0] shp, int h, int w);
		settle();
		write_reg(lcd_pkg::CFG_WRAP, 9'(wrap));
		write_reg(lcd_pkg::CFG_SHAPE, 9'(shp));
		write_reg(lcd_pkg::CFG_HEIGHT, 9'(h));
		write_reg(lcd_pkg::CFG_WIDTH, 9'(w));
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] rand_coord(int size);
		int top;
		int k;
		top = (size > 256) ? 255 : size - 1;
		k = $urandom_range(0, 19);
		if (top < 0 || k <= 3) return 8'($urandom_range(0, 255));
		if (k == 4) return 8'd0;
		if (k == 5) return 8'(top);
		return 8'($urandom_range(0, top));
	endfunction

	task automatic run_random(int count);
		cell_pair_t p;
		for (int i = 0; i < count; i++) begin
			p.first_row  = rand_coord(board.height);
			p.first_col  = rand_coord(board.width);
			p.second_row = rand_coord(board.height);
			p.second_col = rand_coord(board.width);
			send_pair(p);
		end
	endtask

	initial begin
		int h;
		int w;
		bit wrap;
		logic [1:0] shp;

		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_idx            <= lcd_pkg::CFG_WRAP;
		cfg_data           <= '0;
		pair_ch.valid      <= 1'b0;
		pair_ch.first_row  <= '0;
		pair_ch.first_col  <= '0;
		pair_ch.second_row <= '0;
		pair_ch.second_col <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: plane, square, 256 x 256
		send_cells(0, 0, 0, 0);
		send_cells(255, 255, 0, 0);
		send_cells(0, 255, 255, 0);
		send_cells(255, 0, 0, 255);
		send_cells(17, 200, 130, 9);

		apply_config(1'b1, lcd_pkg::SHAPE_CIRCLE, 256, 256);
		send_cells(0, 0, 255, 255);
		send_cells(0, 0, 128, 128);
		send_cells(255, 0, 0, 3);

		apply_config(1'b0, lcd_pkg::SHAPE_HEX, 256, 256);
		send_cells(0, 0, 255, 255);
		send_cells(255, 0, 0, 255);
		send_cells(1, 5, 2, 5);
		send_cells(3, 0, 0, 0);

		// torus with cells beyond the grid
		apply_config(1'b1, lcd_pkg::SHAPE_HEX, 7, 5);
		send_cells(0, 0, 6, 4);
		send_cells(200, 3, 1, 250);
		send_cells(6, 4, 0, 0);

		apply_config(1'b1, lcd_pkg::SHAPE_SQUARE, 1, 1);
		send_cells(0, 0, 255, 255);
		send_cells(0, 200, 0, 0);

		apply_config(1'b0, SHAPE_UNUSED, 256, 256);
		send_cells(255, 255, 0, 0);
		send_cells(10, 10, 20, 20);

		apply_config(1'b0, lcd_pkg::SHAPE_CIRCLE, 256, 256);
		send_cells(0, 0, 255, 255);

		for (int ph = 0; ph < PHASES; ph++) begin
			wrap = ((ph / 6) % 2) != 0;
			shp  = 2'(ph % 3);
			case (ph % 4)
				0: begin h = 256; w = 256; end
				1: begin h = 1; w = 256; end
				2: begin h = $urandom_range(2, 16); w = 1; end
				default: begin h = $urandom_range(1, 256); w = $urandom_range(1, 256); end
			endcase
			apply_config(wrap, shp, h, w);
			run_random(PHASE_ITEMS / 2);
			if (ph == 5) settle();
			run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
		end

		apply_config(1'b1, SHAPE_UNUSED, $urandom_range(1, 256), $urandom_range(1, 256));
		run_random(10);

		// closing stretch at full rate
		apply_config(1'b1, lcd_pkg::SHAPE_HEX, $urandom_range(1, 256),
			$urandom_range(1, 256));
		idle_on = 1'b0;
		run_random(TAIL_ITEMS);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.expected_dist.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
